/* rtl/ecal_pkg.sv */
package ecal_pkg;

  localparam logic [31:0] CHUNK_SECS     = 32'd126230400;
  localparam logic [31:0] DAY_SECS       = 32'd86400;
  localparam logic [31:0] LEAP_YEAR_SECS = 32'd31622400;
  localparam logic [31:0] YEAR_SECS      = 32'd31536000;
  localparam logic [31:0] HOUR_SECS      = 32'd3600;
  localparam logic [31:0] MIN_SECS       = 32'd60;

  localparam logic [11:0] BASE_YEAR     = 12'd2000;
  localparam logic [11:0] CENTURY_YEAR  = 12'd2100;
  localparam logic [5:0]  CENTURY_CHUNK = 6'd25;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } sub_res_t;

  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [31:0] s;
    case (m)
      4'd2:                     s = leap ? 32'd2505600 : 32'd2419200;
      4'd4, 4'd6, 4'd9, 4'd11:  s = 32'd2592000;
      default:                  s = 32'd2678400;
    endcase
    return s;
  endfunction

endpackage

/* rtl/ecal_sub.sv */
module ecal_sub (
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output ecal_pkg::sub_res_t res
);
  import ecal_pkg::*;

  logic [32:0] d;

  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[32];
  assign res.diff = d[31:0];

endmodule

/* rtl/epoch_seconds_to_calendar_top.sv */
// datapath: one shared 32-bit compare-subtract unit stepped through chunk, year, month,
// day, hour, minute
// input: one word in conversion at a time; a new word is taken while
// the previous result waits in the output register
// reset: synchronous active high rst empties the output register and returns to idle
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // epoch_seconds[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // cal_year[11:0], cal_month[15:12], cal_day[20:16],
                                // cal_hour[25:21], cal_minute[31:26], cal_second[37:32],
                                // zero[39:38]
);
  import ecal_pkg::*;

  typedef enum logic [3:0] {
    IDLE, CHUNK, ADJ, YEAR, MONTH, DAY, HOUR, MINUTE, DONE
  } state_t;

  state_t      state;
  logic [31:0] rem;
  logic [2:0]  k;
  logic [5:0]  q;
  logic [11:0] year;
  logic        first;
  logic        leap;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  logic [31:0] operand;
  sub_res_t    sub;
  logic [5:0]  q_next;
  logic [31:0] rem_next;

  always_comb begin
    case (state)
      CHUNK:   operand = CHUNK_SECS << k;
      YEAR:    operand = (first && year != CENTURY_YEAR) ? LEAP_YEAR_SECS : YEAR_SECS;
      MONTH:   operand = month_secs(month, leap);
      DAY:     operand = DAY_SECS << k;
      HOUR:    operand = HOUR_SECS << k;
      MINUTE:  operand = MIN_SECS << k;
      default: operand = '0;
    endcase
  end

  ecal_sub u_sub (
    .a   (rem),
    .b   (operand),
    .res (sub)
  );

  assign q_next   = {q[4:0], sub.ge};
  assign rem_next = sub.ge ? sub.diff : rem;
  assign s_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != DONE) m_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            rem   <= s_tdata;
            k     <= 3'd5;
            q     <= '0;
            state <= CHUNK;
          end
        end
        CHUNK: begin
          rem <= rem_next;
          q   <= q_next;
          if (k == 3'd0) state <= ADJ;
          else k <= k - 3'd1;
        end
        ADJ: begin
          year  <= {4'd0, q, 2'b00} + BASE_YEAR;
          if (q >= CENTURY_CHUNK) rem <= rem + DAY_SECS;
          first <= 1'b1;
          state <= YEAR;
        end
        YEAR: begin
          if (sub.ge) begin
            rem   <= sub.diff;
            year  <= year + 12'd1;
            first <= 1'b0;
          end else begin
            leap  <= first && (year != CENTURY_YEAR);
            month <= MONTH_JAN;
            state <= MONTH;
          end
        end
        MONTH: begin
          rem <= rem_next;
          if (sub.ge && month != MONTH_DEC) begin
            month <= month + 4'd1;
          end else begin
            k     <= 3'd4;
            q     <= '0;
            state <= DAY;
          end
        end
        DAY: begin
          rem <= rem_next;
          q   <= q_next;
          if (k == 3'd0) begin
            day   <= q_next[4:0] + 5'd1;
            k     <= 3'd4;
            q     <= '0;
            state <= HOUR;
          end else begin
            k <= k - 3'd1;
          end
        end
        HOUR: begin
          rem <= rem_next;
          q   <= q_next;
          if (k == 3'd0) begin
            hour  <= q_next[4:0];
            k     <= 3'd5;
            q     <= '0;
            state <= MINUTE;
          end else begin
            k <= k - 3'd1;
          end
        end
        MINUTE: begin
          rem <= rem_next;
          q   <= q_next;
          if (k == 3'd0) begin
            minute <= q_next;
            second <= rem_next[5:0];
            state  <= DONE;
          end else begin
            k <= k - 3'd1;
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, second, minute, hour, day, month, year};
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/ecal_checker.sv */
module ecal_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // output word held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset empties output and returns to idle
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

  // one word at a time in the converter
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // calendar fields in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:0] >= 12'd2000 && m_tdata[11:0] <= 12'd2140
      && m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12
      && m_tdata[20:16] != 5'd0 && m_tdata[25:21] <= 5'd23
      && m_tdata[31:26] <= 6'd59 && m_tdata[37:32] <= 6'd59)
    else $error("calendar field out of range");

endmodule

bind epoch_seconds_to_calendar_top ecal_checker u_ecal_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
